/* design/hsfc_pkg.sv */
// ----------------------------------------------------------------------------
// hsfc_pkg - shared types and constants for the sensor frame check/convert
// Frame kind codes, CRC commands, Q24 conversion coefficients and the
// micro-program of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package hsfc_pkg;

    // Frame kinds
    localparam logic [1:0] ACT_TEMP   = 2'd0;
    localparam logic [1:0] ACT_HUM    = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;

    // Command bytes that lead the CRC stream
    localparam logic [7:0] CMD_TEMP   = 8'h03;
    localparam logic [7:0] CMD_HUM    = 8'h05;
    localparam logic [7:0] CMD_STATUS = 8'h07;

    localparam logic [7:0] CRC_POLY     = 8'h31;
    localparam logic [7:0] SEED_MASK    = 8'hF0;
    localparam logic [7:0] STATUS_ERROR = 8'd254;

    localparam int ACC_W  = 48;
    localparam int COEF_W = 32;
    localparam int OPB_W  = 18;
    localparam int FRAC_W = 24;

    // Accumulator start values in Q24 hundredths
    localparam logic signed [ACC_W-1:0] ACC_INIT_TEMP = -48'sd67276636160;
    localparam logic signed [ACC_W-1:0] ACC_INIT_HUM  = -48'sd4526157333;

    // Micro-program step numbers
    localparam logic [2:0] STEP_HUM_FIRST = 3'd0;
    localparam logic [2:0] STEP_HUM_LAST  = 3'd5;
    localparam logic [2:0] STEP_CELSIUS   = 3'd6;
    localparam logic [2:0] STEP_FAHRENH   = 3'd7;

    typedef struct packed {
        logic                     a_tmp;   // take operand a from the temporary
        logic signed [COEF_W-1:0] coef;    // operand a when not the temporary
        logic                     b_t;     // operand b is comp temperature, else raw
        logic                     to_tmp;  // write product to temporary, else add to acc
    } t_mac_op;

    function automatic t_mac_op hsfc_op(input logic [2:0] step);
        t_mac_op op;
        op = '{a_tmp: 1'b0, coef: '0, b_t: 1'b0, to_tmp: 1'b0};
        unique case (step)
            3'd0: begin op.coef = -32'sd2677;     op.to_tmp = 1'b1; end
            3'd1: begin op.a_tmp = 1'b1; end
            // linear gain and the correction term in x folded together
            3'd2: begin op.coef = 32'sd52834809; end
            3'd3: begin op.coef = 32'sd167772;    op.b_t = 1'b1; end
            3'd4: begin op.coef = 32'sd1342;      op.b_t = 1'b1; op.to_tmp = 1'b1; end
            3'd5: begin op.a_tmp = 1'b1; end
            3'd6: begin op.coef = 32'sd16777216; end
            3'd7: begin op.coef = 32'sd30198989; end
            default: begin op.coef = '0; end
        endcase
        return op;
    endfunction

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

/* design/hsfc_in_if.sv */
// ----------------------------------------------------------------------------
// hsfc_in_if - frame input channel
// Valid/ready handshake carrying one received sensor frame.
// ----------------------------------------------------------------------------
interface hsfc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] raw_value;
    logic [7:0]  crc_received;
    logic        check_enable;
    logic [13:0] comp_temp_raw;

    modport source (output valid, action, raw_value, crc_received, check_enable,
                    comp_temp_raw, input ready);
    modport sink (input valid, action, raw_value, crc_received, check_enable,
                  comp_temp_raw, output ready);
endinterface

/* design/hsfc_out_if.sv */
// ----------------------------------------------------------------------------
// hsfc_out_if - result output channel
// Valid/ready handshake carrying one converted value and its check flag.
// ----------------------------------------------------------------------------
interface hsfc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] value;
    logic               checksum_ok;

    modport source (output valid, value, checksum_ok, input ready);
    modport sink (input valid, value, checksum_ok, output ready);
endinterface

/* design/hsfc_crc.sv */
// ----------------------------------------------------------------------------
// hsfc_crc - bit-serial CRC-8, polynomial 0x31, MSB first
// Loads a seed, then folds in one stream bit per enabled cycle.
// ----------------------------------------------------------------------------
module hsfc_crc
    import hsfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_load,
    input  logic [7:0] i_seed,
    input  logic       i_shift,
    input  logic       i_bit,
    output logic [7:0] o_crc
);

    logic [7:0] r_crc;
    logic [7:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_load) begin
            n_crc = i_seed;
        end else if (i_shift) begin
            n_crc = {r_crc[6:0], 1'b0} ^ ((i_bit != r_crc[7]) ? CRC_POLY : 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

/* design/hsfc_mac.sv */
// ----------------------------------------------------------------------------
// hsfc_mac - shared multiply-accumulate unit
// One 32x18 signed multiply per issue, registered, then written back to the
// temporary or added into the 48-bit Q24 accumulator on the next cycle.
// ----------------------------------------------------------------------------
module hsfc_mac
    import hsfc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_init,
    input  logic signed [ACC_W-1:0] i_init_val,
    input  logic                    i_issue,
    input  t_mac_op                 i_op,
    input  logic [15:0]             i_x,
    input  logic [13:0]             i_t,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [COEF_W-1:0]       opa;
    logic signed [OPB_W-1:0]        opb;
    logic signed [COEF_W+OPB_W-1:0] prod_full;

    logic signed [ACC_W-1:0]  r_prod;
    logic                     r_wb;
    logic                     r_wb_tmp;
    logic signed [COEF_W-1:0] r_tmp;
    logic signed [ACC_W-1:0]  r_acc;

    assign opa       = i_op.a_tmp ? r_tmp : i_op.coef;
    assign opb       = i_op.b_t ? $signed({4'b0000, i_t}) : $signed({2'b00, i_x});
    assign prod_full = opa * opb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= 1'b0;
        end else begin
            r_wb <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            // every product stays well inside 48 bits
            r_prod   <= prod_full[ACC_W-1:0];
            r_wb_tmp <= i_op.to_tmp;
        end
        if (i_init) begin
            r_acc <= i_init_val;
        end else if (r_wb) begin
            if (r_wb_tmp) begin
                r_tmp <= r_prod[COEF_W-1:0];
            end else begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

/* design/humidity_sensor_frame_check_convert_top.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_frame_check_convert_top - sensor frame check and convert
// Verifies the CRC-8 of a received temperature, humidity or status frame
// and converts the raw word to hundredths of a degree or of %RH.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one frame per valid/ready transaction; o_out returns exactly
//   one result per frame, in order. i_cfg_we/i_cfg_wdata set the temperature
//   unit (0 Celsius, 1 Fahrenheit); write it only while the block is idle.
// Timing:
//   A frame runs the serial CRC one bit a cycle (24 bits, 16 for status;
//   skipped when the check is off), then the shared multiplier, an issue
//   phase and a write-back phase per micro-step (six steps for humidity,
//   one for temperature), then S_DONE loads the result into the output
//   register once it is free. i_in.ready is high only while no frame is in
//   progress, so a new frame is taken only after the last has left S_DONE.
// Reset and stall:
//   Reset clears the CRC seed, the unit register and all handshakes.
//   A result waits in the output register while o_out.ready is low; the
//   next frame is accepted meanwhile but its result holds until that slot
//   frees.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_check_convert_top
    import hsfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hsfc_in_if.sink    i_in,
    hsfc_out_if.source o_out,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CRC  = 4'b0010,
        S_MATH = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic        r_temp_unit;
    logic [7:0]  r_crc_seed;
    logic [1:0]  r_action;
    logic [15:0] r_raw;
    logic [7:0]  r_rx;
    logic        r_check;
    logic [13:0] r_t;
    logic [23:0] r_bits;
    logic [4:0]  r_bit_cnt;
    logic [2:0]  r_step;
    logic [2:0]  r_last;
    logic        r_phase;

    logic               r_out_valid;
    logic signed [15:0] r_out_value;
    logic               r_out_ok;

    logic                    accept;
    logic                    conv_frame;
    logic                    status_check;
    logic [7:0]              status_seed;
    logic [7:0]              crc_val;
    logic                    crc_match;
    logic                    mac_issue;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] init_val;
    logic signed [23:0]      q_int;
    logic signed [15:0]      conv_value;
    logic                    out_free;
    logic signed [15:0]      res_value;
    logic                    res_ok;

    assign accept       = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign conv_frame   = (i_in.action == ACT_TEMP) || (i_in.action == ACT_HUM);
    assign status_check = (i_in.action == ACT_STATUS) && i_in.check_enable;
    assign status_seed  = flip8(i_in.raw_value[7:0]) & SEED_MASK;
    assign init_val     = (i_in.action == ACT_HUM) ? ACC_INIT_HUM : ACC_INIT_TEMP;
    assign mac_issue    = (r_state == S_MATH) && !r_phase;
    assign out_free     = !r_out_valid || o_out.ready;

    hsfc_crc u_crc (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_seed  (status_check ? status_seed : r_crc_seed),
        .i_shift (r_state == S_CRC),
        .i_bit   (r_bits[23]),
        .o_crc   (crc_val)
    );

    hsfc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (accept),
        .i_init_val (init_val),
        .i_issue    (mac_issue),
        .i_op       (hsfc_op(r_step)),
        .i_x        (r_raw),
        .i_t        (r_t),
        .o_acc      (acc)
    );

    // drop the Q24 fraction (floor), then saturate to 16 bits
    assign q_int = acc[ACC_W-1:FRAC_W];
    always_comb begin
        if (q_int > 24'sd32767) begin
            conv_value = 16'sh7FFF;
        end else if (q_int < -24'sd32768) begin
            conv_value = -16'sh8000;
        end else begin
            conv_value = q_int[15:0];
        end
    end

    assign crc_match = (flip8(crc_val) == r_rx);

    always_comb begin
        res_value = '0;
        res_ok    = 1'b0;
        case (r_action) inside
            ACT_TEMP, ACT_HUM: begin
                res_value = conv_value;
                res_ok    = !r_check || crc_match;
            end
            ACT_STATUS: begin
                res_ok    = !r_check || crc_match;
                res_value = res_ok ? $signed({8'h00, r_raw[7:0]})
                                   : $signed({8'h00, STATUS_ERROR});
            end
            default: begin
                res_value = '0;
                res_ok    = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.check_enable && (conv_frame || i_in.action == ACT_STATUS)) begin
                        n_state = S_CRC;
                    end else if (conv_frame) begin
                        n_state = S_MATH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CRC: begin
                if (r_bit_cnt == 5'd1) begin
                    n_state = (r_action == ACT_STATUS) ? S_DONE : S_MATH;
                end
            end
            S_MATH: begin
                if (r_phase && r_step == r_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_temp_unit <= 1'b0;
            r_crc_seed  <= '0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_temp_unit <= i_cfg_wdata;
            end
            if (accept && status_check) begin
                r_crc_seed <= status_seed;
            end
            if (accept) begin
                r_phase <= 1'b0;
            end else if (r_state == S_MATH) begin
                r_phase <= !r_phase;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_in.action;
            r_raw    <= i_in.raw_value;
            r_rx     <= i_in.crc_received;
            r_check  <= i_in.check_enable;
            r_t      <= i_in.comp_temp_raw;
            case (i_in.action)
                ACT_TEMP: begin
                    r_bits    <= {CMD_TEMP, i_in.raw_value};
                    r_bit_cnt <= 5'd24;
                end
                ACT_HUM: begin
                    r_bits    <= {CMD_HUM, i_in.raw_value};
                    r_bit_cnt <= 5'd24;
                end
                default: begin
                    r_bits    <= {CMD_STATUS, i_in.raw_value[7:0], 8'h00};
                    r_bit_cnt <= 5'd16;
                end
            endcase
            if (i_in.action == ACT_HUM) begin
                r_step <= STEP_HUM_FIRST;
                r_last <= STEP_HUM_LAST;
            end else begin
                r_step <= r_temp_unit ? STEP_FAHRENH : STEP_CELSIUS;
                r_last <= r_temp_unit ? STEP_FAHRENH : STEP_CELSIUS;
            end
        end else begin
            if (r_state == S_CRC) begin
                r_bits    <= {r_bits[22:0], 1'b0};
                r_bit_cnt <= r_bit_cnt - 5'd1;
            end
            // advance once the write-back of the current step is done
            if (r_state == S_MATH && r_phase && r_step != r_last) begin
                r_step <= r_step + 3'd1;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_value <= res_value;
            r_out_ok    <= res_ok;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.value       = r_out_value;
    assign o_out.checksum_ok = r_out_ok;

endmodule

/* test/humidity_sensor_frame_check_convert_top_tb.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_frame_check_convert_top_tb - frame check and convert test
// Sends temperature, humidity, status and unused-kind frames through the
// input channel, first from a directed table and then at random, with good,
// corrupted and arbitrary checksum bytes in both temperature units. Every
// result is checked in order to its table row or an in-bench conversion
// and CRC; random frames: four pacing modes of sender gaps/receiver stalls.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_check_convert_top_tb;
    import hsfc_pkg::*;

    localparam logic [1:0] ACT_UNUSED      = 2'd3;
    localparam logic       UNIT_CELSIUS    = 1'b0;
    localparam logic       UNIT_FAHRENHEIT = 1'b1;
    localparam int         SETTLE_CYCLES   = 40;
    localparam int         RANDOM_PER_MODE = 132;
    localparam int         NUM_ROWS        = 25;

    typedef enum logic [1:0] {CRC_GIVEN, CRC_GOOD, CRC_BAD} crc_mode_e;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] raw;
        logic [7:0]  crc;
        logic        check;
        logic [13:0] comp;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               ok;
    } reading_t;

    typedef struct packed {
        logic               unit;
        logic [1:0]         action;
        logic [15:0]        raw;
        logic [13:0]        comp;
        logic               check;
        crc_mode_e          mode;
        logic [7:0]         crc;
        logic               typed;
        logic signed [15:0] value;
        logic               ok;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hsfc_in_if  in_ch ();
    hsfc_out_if out_ch ();

    humidity_sensor_frame_check_convert_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model state
    logic [7:0] seed_model;
    logic       unit_model;

    reading_t   expected_readings[$];
    reading_t   head;
    int         idle_pct;
    int         stall_pct;
    int         mismatches;
    int         readings_checked;
    int         frames_sent;
    int         directed_sent;
    int         unit_writes;
    int         kind_count[4];
    frame_t     frame;
    stim_row_t  directed_rows[NUM_ROWS];

    function automatic logic [7:0] reverse_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[i];
        end
        return r;
    endfunction

    // Shift bits in MSB first through CRC-8, polynomial 0x31
    function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [15:0] bits,
                                              input int count);
        logic top;
        for (int i = count - 1; i >= 0; i--) begin
            top = crc[7];
            crc = crc << 1;
            if (bits[i] != top) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Checksum byte the sensor would send for this frame
    function automatic logic [7:0] frame_checksum(input frame_t f, input logic [7:0] seed);
        logic [7:0] r;
        logic [7:0] s;
        case (f.action)
            ACT_TEMP: r = crc8_shift(crc8_shift(seed, CMD_TEMP, 8), f.raw, 16);
            ACT_HUM:  r = crc8_shift(crc8_shift(seed, CMD_HUM, 8), f.raw, 16);
            default: begin
                s = reverse_byte(f.raw[7:0]) & SEED_MASK;
                r = crc8_shift(crc8_shift(s, CMD_STATUS, 8), {8'h00, f.raw[7:0]}, 8);
            end
        endcase
        return reverse_byte(r);
    endfunction

    // Check and convert one frame; a checked status frame reloads the seed
    function automatic reading_t convert_frame(input frame_t f);
        reading_t r;
        longint   x;
        longint   t;
        longint   s;
        longint   q;
        x = longint'(f.raw);
        t = longint'(f.comp);
        r.value = '0;
        r.ok = 1'b1;
        case (f.action)
            ACT_TEMP, ACT_HUM: begin
                if (f.check) begin
                    r.ok = (frame_checksum(f, seed_model) == f.crc);
                end
                if (f.action == ACT_TEMP) begin
                    if (unit_model == UNIT_FAHRENHEIT) begin
                        s = x * 64'sd30198989 - 64'sd4010 * 64'sd16777216;
                    end else begin
                        s = (x - 64'sd4010) * 64'sd16777216;
                    end
                end else begin
                    s = -64'sd3433960571 + 64'sd61572383 * x - 64'sd2677 * x * x
                        + 64'sd167772 * t + 64'sd1342 * t * x - 64'sd1092196762
                        - 64'sd8737574 * x;
                end
                // drop the fraction bits, rounding towards minus infinity
                q = s >>> FRAC_W;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                r.value = q[15:0];
            end
            ACT_STATUS: begin
                r.value = {8'h00, f.raw[7:0]};
                if (f.check) begin
                    seed_model = reverse_byte(f.raw[7:0]) & SEED_MASK;
                    if (frame_checksum(f, seed_model) != f.crc) begin
                        r.ok = 1'b0;
                        r.value = {8'h00, STATUS_ERROR};
                    end
                end
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_crc(input frame_t f, input crc_mode_e mode);
        case (mode)
            CRC_GOOD: return frame_checksum(f, seed_model);
            CRC_BAD:  return ~frame_checksum(f, seed_model);
            default:  return f.crc;
        endcase
    endfunction

    // Present one frame and hold it until the transaction completes
    task automatic send_frame(input frame_t f, input logic typed, input reading_t typed_res);
        reading_t r;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.action        = f.action;
        in_ch.raw_value     = f.raw;
        in_ch.crc_received  = f.crc;
        in_ch.check_enable  = f.check;
        in_ch.comp_temp_raw = f.comp;
        in_ch.valid         = 1'b1;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        r = convert_frame(f);
        expected_readings.push_back(typed ? typed_res : r);
        frames_sent++;
        kind_count[f.action]++;
    endtask

    // Hold the sender until every reading is back and the block has gone quiet
    task automatic wait_until_settled();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_unit(input logic u);
        wait_until_settled();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = u;
        @(negedge clk);
        cfg_we    = 1'b0;
        unit_model = u;
        unit_writes++;
    endtask

    function automatic frame_t random_frame();
        frame_t    f;
        int        pick;
        crc_mode_e mode;
        pick = $urandom_range(99);
        f.action = (pick < 38) ? ACT_TEMP : (pick < 76) ? ACT_HUM :
                   (pick < 94) ? ACT_STATUS : ACT_UNUSED;
        case (f.action)
            ACT_TEMP: f.raw = ($urandom_range(9) != 0) ? 16'($urandom_range(16383))
                                                        : 16'($urandom);
            ACT_HUM:  f.raw = ($urandom_range(6) != 0) ? 16'($urandom_range(4095))
                                                        : 16'($urandom);
            default:  f.raw = ($urandom_range(9) < 7) ? 16'($urandom_range(255))
                                                       : 16'($urandom);
        endcase
        f.comp  = ($urandom_range(9) < 7) ? 14'($urandom_range(10000, 2000))
                                           : 14'($urandom);
        f.check = ($urandom_range(4) != 0);
        f.crc   = 8'($urandom);
        pick = $urandom_range(99);
        mode = (pick < 60) ? CRC_GOOD : (pick < 85) ? CRC_BAD : CRC_GIVEN;
        if (mode == CRC_GOOD) begin
            f.crc = frame_checksum(f, seed_model);
        end else if (mode == CRC_BAD) begin
            // single-bit corruption of the good checksum
            f.crc = frame_checksum(f, seed_model) ^ (8'h01 << $urandom_range(7));
        end
        return f;
    endfunction

    task automatic report(input string what, input reading_t want, input reading_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected value %0d ok %0b, got value %0d ok %0b",
                     what, want.value, want.ok, got.value, got.ok);
        end
    endtask

    // Receiver: stall at random, change ready on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            readings_checked++;
            if (expected_readings.size() == 0) begin
                report("reading with no frame outstanding", '0,
                       {out_ch.value, out_ch.checksum_ok});
            end else begin
                head = expected_readings.pop_front();
                if (out_ch.value !== head.value || out_ch.checksum_ok !== head.ok) begin
                    report("reading mismatch", head, {out_ch.value, out_ch.checksum_ok});
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        directed_rows = '{
            '{UNIT_CELSIUS, ACT_TEMP, 16'd0, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b1, -16'sd4010, 1'b1},
            '{UNIT_CELSIUS, ACT_TEMP, 16'd4010, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b1, 16'sd0, 1'b1},
            '{UNIT_CELSIUS, ACT_TEMP, 16'd16383, 14'd0, 1'b1, CRC_GOOD, 8'h00,
              1'b1, 16'sd12373, 1'b1},
            '{UNIT_CELSIUS, ACT_TEMP, 16'hFFFF, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b1, 16'sd32767, 1'b1},
            '{UNIT_CELSIUS, ACT_TEMP, 16'h1234, 14'd0, 1'b1, CRC_GIVEN, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_HUM, 16'd0, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_HUM, 16'd4095, 14'h3FFF, 1'b1, CRC_GOOD, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_HUM, 16'hFFFF, 14'h3FFF, 1'b0, CRC_GIVEN, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_HUM, 16'd1500, 14'd6400, 1'b1, CRC_GOOD, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_HUM, 16'hFFFF, 14'd0, 1'b1, CRC_BAD, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_STATUS, 16'h0000, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b1, 16'sd0, 1'b1},
            '{UNIT_CELSIUS, ACT_STATUS, 16'hFFFF, 14'h3FFF, 1'b0, CRC_GIVEN, 8'hFF,
              1'b1, 16'sd255, 1'b1},
            '{UNIT_CELSIUS, ACT_STATUS, 16'h0040, 14'd0, 1'b1, CRC_GOOD, 8'h00,
              1'b1, 16'sd64, 1'b1},
            '{UNIT_CELSIUS, ACT_STATUS, 16'h00A5, 14'd0, 1'b1, CRC_BAD, 8'h00,
              1'b1, 16'sd254, 1'b0},
            '{UNIT_CELSIUS, ACT_TEMP, 16'h2000, 14'd0, 1'b1, CRC_GOOD, 8'h00,
              1'b1, 16'sd4182, 1'b1},
            '{UNIT_CELSIUS, ACT_UNUSED, 16'h1234, 14'h0155, 1'b1, CRC_GIVEN, 8'h5A,
              1'b1, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_UNUSED, 16'hFFFF, 14'h3FFF, 1'b0, CRC_GIVEN, 8'hFF,
              1'b1, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_STATUS, 16'h00F0, 14'd0, 1'b1, CRC_GOOD, 8'h00,
              1'b1, 16'sd240, 1'b1},
            '{UNIT_CELSIUS, ACT_HUM, 16'd2000, 14'd6000, 1'b1, CRC_BAD, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_TEMP, 16'd8000, 14'd0, 1'b1, CRC_BAD, 8'h00,
              1'b1, 16'sd3990, 1'b0},
            '{UNIT_FAHRENHEIT, ACT_TEMP, 16'd0, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b1, -16'sd4010, 1'b1},
            '{UNIT_FAHRENHEIT, ACT_TEMP, 16'd16383, 14'd0, 1'b1, CRC_GOOD, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_FAHRENHEIT, ACT_TEMP, 16'hFFFF, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b1, 16'sd32767, 1'b1},
            '{UNIT_FAHRENHEIT, ACT_HUM, 16'd3000, 14'd8000, 1'b1, CRC_GOOD, 8'h00,
              1'b0, 16'sd0, 1'b0},
            '{UNIT_CELSIUS, ACT_TEMP, 16'd4011, 14'd0, 1'b0, CRC_GIVEN, 8'h00,
              1'b1, 16'sd1, 1'b1}
        };

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.action         = ACT_TEMP;
        in_ch.raw_value      = '0;
        in_ch.crc_received   = '0;
        in_ch.check_enable   = 1'b0;
        in_ch.comp_temp_raw  = '0;
        out_ch.ready         = 1'b0;
        seed_model           = '0;
        unit_model           = UNIT_CELSIUS;
        idle_pct             = 0;
        stall_pct            = 0;
        mismatches           = 0;
        readings_checked     = 0;
        frames_sent          = 0;
        unit_writes          = 0;
        kind_count           = '{0, 0, 0, 0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_unit(UNIT_CELSIUS);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (directed_rows[i].unit != unit_model) begin
                write_unit(directed_rows[i].unit);
            end
            frame.action = directed_rows[i].action;
            frame.raw    = directed_rows[i].raw;
            frame.comp   = directed_rows[i].comp;
            frame.check  = directed_rows[i].check;
            frame.crc    = directed_rows[i].crc;
            frame.crc    = pick_crc(frame, directed_rows[i].mode);
            send_frame(frame, directed_rows[i].typed,
                       {directed_rows[i].value, directed_rows[i].ok});
        end
        directed_sent = frames_sent;

        // Pacing modes: free-running, sparse sender, stalling receiver, both
        for (int m = 0; m < 4; m++) begin
            case (m)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 88; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            write_unit((m == 3) ? logic'($urandom_range(1)) : logic'(m % 2 == 0));
            repeat (RANDOM_PER_MODE) begin
                // now and then let the pipeline empty completely
                if ($urandom_range(59) == 0) begin
                    wait_until_settled();
                end
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        wait_until_settled();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d frames (%0d from the table): %0d temperature, %0d humidity,",
                 frames_sent, directed_sent, kind_count[0], kind_count[1]);
        $display("%0d status, %0d unused kind; %0d unit writes, %0d readings, %0d mismatches",
                 kind_count[2], kind_count[3], unit_writes, readings_checked, mismatches);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
